### hw/rtl/dms_pkg.sv
// Shared types and constants of the shortest-path block.
package dms_pkg;

   localparam int DIST_W      = 27;
   localparam int NODE_CNT_W  = 4;
   localparam int NO_EDGE_W   = 24;
   localparam int EDGE_IN_W   = 24;
   localparam int SUM_W       = 33;

   localparam logic [DIST_W-1:0]     DIST_MAX      = 27'd134217727;
   localparam logic [NODE_CNT_W-1:0] NODE_CNT_RST  = 4'd8;
   localparam logic [NO_EDGE_W-1:0]  NO_EDGE_RST   = 24'd9999999;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_START = 1'b1;

   localparam logic REG_NODE_COUNT = 1'b0;
   localparam logic REG_NO_EDGE    = 1'b1;

   typedef struct packed {
      logic load_weight;
      logic start_run;
      logic next_round;
      logic scan;
      logic init_pass;
      logic rsp_load;
      logic rsp_last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic found;
      logic rsp_free;
   } dp_status_type;

endpackage

### hw/rtl/dms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/dms_datapath.sv
// Datapath: weight and node memories, relax and minimum-pick logic, result register.
module dms_datapath #(
   parameter int MAX_VERTICES = 8,
   parameter int WEIGHT_BITS  = 24,
   localparam int VW = $clog2(MAX_VERTICES)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dms_pkg::ctrl_cmd_type         cmd,
   input  logic [VW-1:0]                 idx,
   input  logic [VW-1:0]                 req_row,
   input  logic [VW-1:0]                 req_col,
   input  logic [dms_pkg::EDGE_IN_W-1:0] req_weight,
   input  logic [VW-1:0]                 req_src,
   input  logic [dms_pkg::NO_EDGE_W-1:0] no_edge,
   output dms_pkg::dp_status_type        status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [VW-1:0]                 rsp_vertex,
   output logic [dms_pkg::DIST_W-1:0]    rsp_dist,
   output logic [VW-1:0]                 rsp_pred,
   output logic                          rsp_pred_valid,
   output logic                          rsp_last
);

   localparam int WDEPTH = MAX_VERTICES * MAX_VERTICES;
   localparam int WA     = $clog2(WDEPTH);
   localparam int NODE_W = dms_pkg::DIST_W + VW + 1;

   // weight memory
   logic                   w_wr_en;
   logic [WA-1:0]          w_wr_addr;
   logic [WA-1:0]          w_rd_addr;
   logic [WEIGHT_BITS-1:0] w_rd_data;

   // node memory: {known, prior, distance}
   logic                   n_wr_en;
   logic [NODE_W-1:0]      n_wr_data;
   logic [NODE_W-1:0]      n_rd_data;

   logic [VW-1:0]                 u_ff, u_in;
   logic [VW-1:0]                 src_ff, src_in;
   logic [dms_pkg::DIST_W-1:0]    du_ff, du_in;
   logic [dms_pkg::DIST_W-1:0]    min_ff, min_in;
   logic [VW-1:0]                 pos_ff, pos_in;
   logic                          found_ff, found_in;
   logic [MAX_VERTICES-1:0]       visited_ff, visited_in;
   logic                          scan_d_ff, init_d_ff;
   logic [VW-1:0]                 w_d_ff;

   logic                          rsp_valid_ff;
   logic [VW-1:0]                 rsp_vertex_ff;
   logic [dms_pkg::DIST_W-1:0]    rsp_dist_ff;
   logic [VW-1:0]                 rsp_pred_ff;
   logic                          rsp_pred_valid_ff;
   logic                          rsp_last_ff;

   logic [dms_pkg::SUM_W-1:0]     c_ext;
   logic [dms_pkg::SUM_W-1:0]     sum;
   logic [dms_pkg::DIST_W-1:0]    sum_sat;
   logic [dms_pkg::DIST_W-1:0]    init_dist;
   logic [dms_pkg::DIST_W-1:0]    old_dist;
   logic [dms_pkg::DIST_W-1:0]    cand_dist;
   logic                          improve;
   logic                          take;

   assign w_wr_en   = cmd.load_weight && (int'(req_row) < MAX_VERTICES)
                      && (int'(req_col) < MAX_VERTICES);
   assign w_wr_addr = WA'(int'(req_row) * MAX_VERTICES + int'(req_col));
   assign w_rd_addr = WA'(int'(u_ff) * MAX_VERTICES + int'(idx));

   dms_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (WDEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (w_wr_addr),
      .wr_data (WEIGHT_BITS'(req_weight)),
      .rd_addr (w_rd_addr),
      .rd_data (w_rd_data)
   );

   dms_ram #(
      .WIDTH (NODE_W),
      .DEPTH (MAX_VERTICES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (n_wr_en),
      .wr_addr (w_d_ff),
      .wr_data (n_wr_data),
      .rd_addr (idx),
      .rd_data (n_rd_data)
   );

   // second scan stage: the weight and the old node entry of w_d_ff are here
   always_comb begin
      c_ext     = dms_pkg::SUM_W'(w_rd_data);
      old_dist  = n_rd_data[dms_pkg::DIST_W-1:0];
      sum       = dms_pkg::SUM_W'(du_ff) + c_ext;
      sum_sat   = (sum > dms_pkg::SUM_W'(dms_pkg::DIST_MAX)) ? dms_pkg::DIST_MAX
                                                              : sum[dms_pkg::DIST_W-1:0];
      if (w_d_ff == src_ff) begin
         init_dist = '0;
      end else if (c_ext > dms_pkg::SUM_W'(dms_pkg::DIST_MAX)) begin
         init_dist = dms_pkg::DIST_MAX;
      end else begin
         init_dist = c_ext[dms_pkg::DIST_W-1:0];
      end
      improve = (c_ext != dms_pkg::SUM_W'(no_edge)) && (sum_sat < old_dist);

      if (init_d_ff) begin
         n_wr_data = {1'b0, {VW{1'b0}}, init_dist};
      end else if (improve) begin
         n_wr_data = {1'b1, u_ff, sum_sat};
      end else begin
         n_wr_data = n_rd_data;
      end
      n_wr_en   = scan_d_ff && (init_d_ff || improve);
      cand_dist = n_wr_data[dms_pkg::DIST_W-1:0];
      // min starts at the no-edge value, so one compare covers both bounds
      take      = scan_d_ff && !visited_ff[w_d_ff] && (cand_dist < min_ff);
   end

   always_comb begin
      u_in       = u_ff;
      src_in     = src_ff;
      du_in      = du_ff;
      min_in     = min_ff;
      pos_in     = pos_ff;
      found_in   = found_ff;
      visited_in = visited_ff;
      if (take) begin
         min_in   = cand_dist;
         pos_in   = w_d_ff;
         found_in = 1'b1;
      end
      if (cmd.start_run) begin
         u_in       = req_src;
         src_in     = req_src;
         min_in     = dms_pkg::DIST_W'(no_edge);
         found_in   = 1'b0;
         visited_in = '0;
         if (int'(req_src) < MAX_VERTICES) begin
            visited_in[req_src] = 1'b1;
         end
      end
      if (cmd.next_round) begin
         u_in             = pos_ff;
         du_in            = min_ff;
         min_in           = dms_pkg::DIST_W'(no_edge);
         found_in         = 1'b0;
         visited_in[pos_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_d_ff    <= 1'b0;
         init_d_ff    <= 1'b0;
         found_ff     <= 1'b0;
         visited_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_d_ff  <= cmd.scan;
         init_d_ff  <= cmd.init_pass;
         found_ff   <= found_in;
         visited_ff <= visited_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      w_d_ff <= idx;
      u_ff   <= u_in;
      src_ff <= src_in;
      du_ff  <= du_in;
      min_ff <= min_in;
      pos_ff <= pos_in;
      if (cmd.rsp_load) begin
         rsp_vertex_ff     <= idx;
         rsp_dist_ff       <= n_rd_data[dms_pkg::DIST_W-1:0];
         rsp_pred_ff       <= n_rd_data[NODE_W-2:dms_pkg::DIST_W];
         rsp_pred_valid_ff <= n_rd_data[NODE_W-1];
         rsp_last_ff       <= cmd.rsp_last;
      end
   end

   assign status.found    = found_ff;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_vertex     = rsp_vertex_ff;
   assign rsp_dist       = rsp_dist_ff;
   assign rsp_pred       = rsp_pred_ff;
   assign rsp_pred_valid = rsp_pred_valid_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

### hw/rtl/dms_ctrl.sv
// Controller: sequences load, init pass, relax rounds and result readout.
module dms_ctrl #(
   parameter int MAX_VERTICES = 8,
   localparam int VW = $clog2(MAX_VERTICES),
   localparam int NW = $clog2(MAX_VERTICES + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_op,
   input  logic [VW-1:0]                  req_src,
   input  logic [dms_pkg::NODE_CNT_W-1:0] node_count,
   input  dms_pkg::dp_status_type         status,
   output dms_pkg::ctrl_cmd_type          cmd,
   output logic [VW-1:0]                  idx
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_OUT_RD,
      ST_OUT_WR
   } state_type;

   state_type     state_ff;
   logic [VW-1:0] idx_ff;
   logic [NW-1:0] n_ff;
   logic [NW-1:0] rounds_ff;
   logic          init_ff;

   logic [NW-1:0] n_in;
   logic          accept;
   logic          start_ok;
   logic          at_last;

   assign n_in = (int'(node_count) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(node_count);
   assign accept   = req_valid && req_ready;
   assign start_ok = accept && (req_op == dms_pkg::OP_START)
                     && (int'(req_src) < MAX_VERTICES) && (n_in != '0);
   assign at_last  = (NW'(idx_ff) == n_ff - NW'(1));

   assign req_ready = (state_ff == ST_IDLE);
   assign idx       = idx_ff;

   always_comb begin
      cmd             = '0;
      cmd.load_weight = accept && (req_op == dms_pkg::OP_LOAD);
      cmd.start_run   = start_ok;
      case (state_ff)
         ST_SCAN: begin
            cmd.scan      = 1'b1;
            cmd.init_pass = init_ff;
         end
         ST_DECIDE: begin
            cmd.next_round = (rounds_ff != '0) && status.found;
         end
         ST_OUT_WR: begin
            cmd.rsp_load = status.rsp_free;
            cmd.rsp_last = at_last;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         idx_ff    <= '0;
         n_ff      <= '0;
         rounds_ff <= '0;
         init_ff   <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start_ok) begin
                  n_ff      <= n_in;
                  rounds_ff <= (n_in >= NW'(2)) ? n_in - NW'(2) : '0;
                  init_ff   <= 1'b1;
                  idx_ff    <= '0;
                  state_ff  <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (at_last) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  idx_ff <= idx_ff + VW'(1);
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               idx_ff <= '0;
               // stop early once nothing unvisited is reachable
               if ((rounds_ff != '0) && status.found) begin
                  rounds_ff <= rounds_ff - NW'(1);
                  init_ff   <= 1'b0;
                  state_ff  <= ST_SCAN;
               end else begin
                  state_ff <= ST_OUT_RD;
               end
            end
            ST_OUT_RD: begin
               state_ff <= ST_OUT_WR;
            end
            ST_OUT_WR: begin
               if (status.rsp_free) begin
                  if (at_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + VW'(1);
                     state_ff <= ST_OUT_RD;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### hw/rtl/dijkstra_matrix_shortest_path.sv
// Top level: single-source shortest paths over a stored adjacency matrix.
//
// Request beats on req_*: req_tuser selects the kind. A load beat writes one
// edge weight into the matrix memory. A start beat runs the search from its
// source vertex; one whose source is at or beyond MAX_VERTICES, or that
// comes with node_count zero, is dropped without results. A run emits one
// rsp beat per vertex in index order, with rsp_tlast on the final vertex.
// Run flow with n vertices in use: an init pass, then up to n-2 relax rounds
// (one pass over the weight row and the node memory per round, relax and
// next-minimum pick fused), then the readout, in which each result beat is
// read from the node memory (ST_OUT_RD) and then loaded into the output
// register (ST_OUT_WR). req_tready is high only between runs; a start beat
// may be taken while the last result beat still waits in the output register.
// When rsp_tready is low the result register holds its beat and the readout
// pauses. csr_* writes node_count (index 0) and no_edge_value (index 1), is
// always ready; the user must see that they are made only while the block is
// idle, as the block does not enforce it. Reset is synchronous: it returns the
// controller to idle, empties the output register and restores node_count
// to 8 and no_edge_value to 9999999. The matrix holds no reset; the user must
// see that every entry is loaded before it is used; the block does not check.
module dijkstra_matrix_shortest_path #(
   parameter int MAX_VERTICES = 8,
   parameter int WEIGHT_BITS  = 24,
   localparam int VW    = $clog2(MAX_VERTICES),
   localparam int REQ_W = ((3 * VW + dms_pkg::EDGE_IN_W) + 7) / 8 * 8,
   localparam int RSP_W = ((2 * VW + dms_pkg::DIST_W + 1) + 7) / 8 * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // row_vertex, col_vertex, edge_weight, source_vertex, zero pad
   input  logic [REQ_W-1:0]              req_tdata,
   // op
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // vertex, path_distance, predecessor, predecessor_valid, zero pad
   output logic [RSP_W-1:0]              rsp_tdata,
   output logic                          rsp_tlast,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [dms_pkg::NO_EDGE_W-1:0] csr_data
);

   logic [dms_pkg::NODE_CNT_W-1:0] node_count_ff;
   logic [dms_pkg::NO_EDGE_W-1:0]  no_edge_ff;

   logic [VW-1:0]                 req_row;
   logic [VW-1:0]                 req_col;
   logic [dms_pkg::EDGE_IN_W-1:0] req_weight;
   logic [VW-1:0]                 req_src;

   dms_pkg::ctrl_cmd_type         cmd;
   dms_pkg::dp_status_type        status;
   logic [VW-1:0]                 idx;

   logic [VW-1:0]                 rsp_vertex;
   logic [dms_pkg::DIST_W-1:0]    rsp_dist;
   logic [VW-1:0]                 rsp_pred;
   logic                          rsp_pred_valid;

   assign req_row    = req_tdata[VW-1:0];
   assign req_col    = req_tdata[2*VW-1:VW];
   assign req_weight = req_tdata[2*VW+dms_pkg::EDGE_IN_W-1:2*VW];
   assign req_src    = req_tdata[3*VW+dms_pkg::EDGE_IN_W-1:2*VW+dms_pkg::EDGE_IN_W];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= dms_pkg::NODE_CNT_RST;
         no_edge_ff    <= dms_pkg::NO_EDGE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dms_pkg::REG_NODE_COUNT: node_count_ff <= csr_data[dms_pkg::NODE_CNT_W-1:0];
            dms_pkg::REG_NO_EDGE:    no_edge_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   dms_ctrl #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_op     (req_tuser),
      .req_src    (req_src),
      .node_count (node_count_ff),
      .status     (status),
      .cmd        (cmd),
      .idx        (idx)
   );

   dms_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .idx            (idx),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_weight     (req_weight),
      .req_src        (req_src),
      .no_edge        (no_edge_ff),
      .status         (status),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_vertex     (rsp_vertex),
      .rsp_dist       (rsp_dist),
      .rsp_pred       (rsp_pred),
      .rsp_pred_valid (rsp_pred_valid),
      .rsp_last       (rsp_tlast)
   );

   assign rsp_tdata = RSP_W'({rsp_pred_valid, rsp_pred, rsp_dist, rsp_vertex});

endmodule

### verif/tb_dijkstra_matrix_shortest_path.sv
// Testbench for the adjacency-matrix shortest-path block: loads, runs and result checks.
`timescale 1ns / 1ps

module tb_dijkstra_matrix_shortest_path;

   localparam int REQ_W    = 40;
   localparam int RSP_W    = 40;
   localparam int IDLE_GAP = 150;

   typedef struct packed {
      logic [2:0]                 vertex;
      logic [dms_pkg::DIST_W-1:0] path_dist;
      logic [2:0]                 pred;
      logic                       pred_ok;
      logic                       last;
   } path_entry_type;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [REQ_W-1:0]              req_tdata  = '0;
   logic                          req_tuser  = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [RSP_W-1:0]              rsp_tdata;
   logic                          rsp_tlast;
   logic                          csr_valid  = 1'b0;
   logic                          csr_ready;
   logic                          csr_index  = 1'b0;
   logic [dms_pkg::NO_EDGE_W-1:0] csr_data   = '0;

   // shadow of the block's matrix and registers
   logic [dms_pkg::EDGE_IN_W-1:0] weights [8][8];
   logic [3:0]                    cfg_nodes   = dms_pkg::NODE_CNT_RST;
   logic [dms_pkg::NO_EDGE_W-1:0] cfg_no_edge = dms_pkg::NO_EDGE_RST;

   path_entry_type pending_paths[$];
   bit          steady       = 1'b0;
   int          mismatches   = 0;
   int          loads_sent   = 0;
   int          runs_sent    = 0;
   int          beats_seen   = 0;
   int          csr_writes   = 0;

   dijkstra_matrix_shortest_path DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= steady ? 1'b1 : ($urandom_range(99) >= 38);
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      mismatches++;
   endtask

   // Work out the per-vertex distances and predecessors of a run from src.
   task automatic predict_paths(input logic [2:0] src);
      int                         n;
      int                         rounds;
      int                         pick;
      logic [dms_pkg::DIST_W-1:0] dist_v [8];
      bit                         seen [8];
      bit                         known [8];
      logic [2:0]                 prv [8];
      logic [dms_pkg::DIST_W:0]   sum;
      logic [dms_pkg::DIST_W-1:0] least;
      path_entry_type             e;
      n = (cfg_nodes > 8) ? 8 : cfg_nodes;
      for (int i = 0; i < 8; i++) begin
         seen[i]   = 1'b0;
         known[i]  = 1'b0;
         prv[i]    = '0;
         dist_v[i] = (i < n) ? dms_pkg::DIST_W'(weights[src][i]) : '0;
      end
      seen[src]   = 1'b1;
      dist_v[src] = '0;
      rounds = (n >= 2) ? n - 2 : 0;
      for (int r = 0; r < rounds; r++) begin
         least = dms_pkg::DIST_W'(cfg_no_edge);
         pick  = -1;
         for (int i = 0; i < n; i++) begin
            if (!seen[i] && dist_v[i] < least) begin
               least = dist_v[i];
               pick  = i;
            end
         end
         // stop early once nothing below the no-edge value is left
         if (pick < 0) break;
         seen[pick] = 1'b1;
         for (int w = 0; w < n; w++) begin
            if (weights[pick][w] != cfg_no_edge) begin
               sum = dist_v[pick] + weights[pick][w];
               if (sum > dms_pkg::DIST_MAX) sum = dms_pkg::DIST_MAX;
               if (sum < dist_v[w]) begin
                  dist_v[w] = sum[dms_pkg::DIST_W-1:0];
                  prv[w]    = pick[2:0];
                  known[w]  = 1'b1;
               end
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         e.vertex    = i[2:0];
         e.path_dist = dist_v[i];
         e.pred      = known[i] ? prv[i] : 3'd0;
         e.pred_ok   = known[i];
         e.last      = (i + 1 == n);
         pending_paths.push_back(e);
      end
   endtask

   always @(posedge clock) begin : check_results
      path_entry_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_seen++;
         if (pending_paths.size() == 0) begin
            report_mismatch("result beat with none pending, vertex", rsp_tdata[2:0], -1);
         end else begin
            want = pending_paths.pop_front();
            if (rsp_tdata[2:0] != want.vertex)
               report_mismatch("vertex", rsp_tdata[2:0], want.vertex);
            if (rsp_tdata[29:3] != want.path_dist)
               report_mismatch("path_distance", rsp_tdata[29:3], want.path_dist);
            if (rsp_tdata[32:30] != want.pred)
               report_mismatch("predecessor", rsp_tdata[32:30], want.pred);
            if (rsp_tdata[33] != want.pred_ok)
               report_mismatch("predecessor_valid", rsp_tdata[33], want.pred_ok);
            if (rsp_tlast != want.last)
               report_mismatch("last_result", rsp_tlast, want.last);
         end
      end
   end

   // Send one request beat, after a random gap unless steady is set; hold valid until accepted.
   task automatic send_request(input logic op, input logic [2:0] row, input logic [2:0] col,
                               input logic [dms_pkg::EDGE_IN_W-1:0] w,
                               input logic [2:0] src);
      int gap;
      gap = 0;
      while (!steady && $urandom_range(99) < 38) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, src, w, col, row};
      do @(posedge clock); while (!req_tready);
      if (op == dms_pkg::OP_LOAD) begin
         weights[row][col] = w;
         loads_sent++;
      end else begin
         predict_paths(src);
         runs_sent++;
      end
   endtask

   task automatic load_weight(input logic [2:0] row, input logic [2:0] col,
                              input logic [dms_pkg::EDGE_IN_W-1:0] w);
      send_request(dms_pkg::OP_LOAD, row, col, w, 3'($urandom));
   endtask

   task automatic start_run(input logic [2:0] src);
      send_request(dms_pkg::OP_START, 3'($urandom), 3'($urandom),
                   dms_pkg::EDGE_IN_W'($urandom), src);
   endtask

   // Weights biased toward short edges, no-edge markers and values around them.
   function automatic logic [dms_pkg::EDGE_IN_W-1:0] rand_weight();
      int k;
      k = $urandom_range(99);
      if (k < 20) return cfg_no_edge;
      if (k < 30) return '0;
      if (k < 70) return dms_pkg::EDGE_IN_W'($urandom_range(1, 60));
      if (k < 80) return dms_pkg::EDGE_IN_W'(cfg_no_edge + $urandom_range(0, 2) - 1);
      return dms_pkg::EDGE_IN_W'($urandom);
   endfunction

   // Drain all pending results, then let the block settle.
   task automatic wait_idle();
      int guard;
      req_tvalid <= 1'b0;
      guard = 0;
      while (pending_paths.size() > 0 && guard < 50000) begin
         @(posedge clock);
         guard++;
      end
      repeat (IDLE_GAP) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [dms_pkg::NO_EDGE_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == dms_pkg::REG_NODE_COUNT) cfg_nodes = value[3:0];
      else cfg_no_edge = value;
      csr_writes++;
   endtask

   task automatic set_node_count(input logic [3:0] n);
      logic [dms_pkg::NO_EDGE_W-1:0] value;
      value      = dms_pkg::NO_EDGE_W'($urandom);
      value[3:0] = n;
      write_csr(dms_pkg::REG_NODE_COUNT, value);
   endtask

   task automatic test_fill_matrix();
      for (int r = 0; r < 8; r++)
         for (int c = 0; c < 8; c++)
            load_weight(r[2:0], c[2:0], rand_weight());
   endtask

   task automatic test_directed_paths();
      load_weight(3'd0, 3'd7, '0);
      load_weight(3'd7, 3'd0, '1);
      load_weight(3'd0, 3'd3, cfg_no_edge);
      start_run(3'd0);
      start_run(3'd7);
      // isolate vertex 5: nothing reachable from it
      for (int c = 0; c < 8; c++) load_weight(3'd5, c[2:0], cfg_no_edge);
      start_run(3'd5);
   endtask

   task automatic test_node_count_range();
      set_node_count(4'd2);
      start_run(3'd1);
      set_node_count(4'd3);
      start_run(3'd6);
      set_node_count(4'd1);
      start_run(3'd0);
      set_node_count(4'd0);
      start_run(3'd2);
      set_node_count(4'd15);
      start_run(3'd4);
      set_node_count(4'd8);
   endtask

   task automatic test_no_edge_extremes();
      write_csr(dms_pkg::REG_NO_EDGE, 24'd1);
      start_run(3'd3);
      write_csr(dms_pkg::REG_NO_EDGE, '1);
      start_run(3'd0);
      write_csr(dms_pkg::REG_NO_EDGE, dms_pkg::NO_EDGE_RST);
      start_run(3'd6);
   endtask

   task automatic test_random_graphs();
      int k;
      for (int phase = 0; phase < 6; phase++) begin
         k = $urandom_range(99);
         if (k < 25) set_node_count(4'd2);
         else if (k < 50) set_node_count(4'd8);
         else set_node_count(4'($urandom_range(3, 7)));
         k = $urandom_range(99);
         if (k < 50) write_csr(dms_pkg::REG_NO_EDGE, dms_pkg::NO_EDGE_RST);
         else if (k < 70)
            write_csr(dms_pkg::REG_NO_EDGE, dms_pkg::NO_EDGE_W'($urandom_range(50, 200)));
         else if (k < 85) write_csr(dms_pkg::REG_NO_EDGE, '1);
         else write_csr(dms_pkg::REG_NO_EDGE, dms_pkg::NO_EDGE_W'($urandom));
         for (int i = 0; i < 25; i++) begin
            if ($urandom_range(99) < 30) start_run(3'($urandom));
            else load_weight(3'($urandom), 3'($urandom), rand_weight());
         end
      end
   endtask

   task automatic test_back_to_back();
      wait_idle();
      set_node_count(4'd8);
      write_csr(dms_pkg::REG_NO_EDGE, dms_pkg::NO_EDGE_RST);
      steady <= 1'b1;
      for (int i = 0; i < 20; i++) begin
         if (i % 4 == 3) start_run(3'($urandom));
         else load_weight(3'($urandom), 3'($urandom),
                          dms_pkg::EDGE_IN_W'($urandom_range(0, 40)));
      end
      wait_idle();
      steady <= 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_matrix();
      test_directed_paths();
      test_node_count_range();
      test_no_edge_extremes();
      test_random_graphs();
      test_back_to_back();
      wait_idle();
      if (pending_paths.size() != 0)
         report_mismatch("results never delivered", 0, pending_paths.size());
      $display("Covered %0d weight loads, %0d runs, %0d result beats, %0d register writes,",
               loads_sent, runs_sent, beats_seen, csr_writes);
      $display("vertex counts 0..15, no-edge values from 1 to full scale, random stalls.");
      if (mismatches == 0) begin
         $display("** dijkstra_matrix_shortest_path: PASSED **");
      end else begin
         $display("** dijkstra_matrix_shortest_path: FAILED **");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout: run did not complete");
      $display("** dijkstra_matrix_shortest_path: FAILED **");
      $finish;
   end

endmodule

### dijkstra_matrix_shortest_path.f
hw/rtl/dms_pkg.sv
hw/rtl/dms_ram.sv
hw/rtl/dms_datapath.sv
hw/rtl/dms_ctrl.sv
hw/rtl/dijkstra_matrix_shortest_path.sv
verif/tb_dijkstra_matrix_shortest_path.sv
